// File: hdl/mwsm_pkg.sv
// Shared types, widths and register codes for the mecanum wheel speed mapper.
`timescale 1ns / 1ps

package mwsm_pkg;

    // Fixed point layout: every rpm term carries 29 fraction bits
    localparam int FRAC_BITS  = 29;
    localparam int IN_W       = 16;
    localparam int RPM_W      = 16;
    localparam int LIM_W      = 15;
    localparam int GAIN_W     = IN_W + 1;
    localparam int PROD_W     = 2 * GAIN_W;
    localparam int VEL_SHIFT  = FRAC_BITS - 16;
    localparam int TERM_W     = PROD_W + VEL_SHIFT + 1;
    localparam int MAG_W      = TERM_W - 1;
    localparam int Q_W        = LIM_W;
    localparam int NUM_W      = MAG_W + LIM_W;
    localparam int NUM_WHEELS = 4;

    // Output queue
    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Joystick throttle clamp bounds, Q1.14
    localparam logic signed [IN_W-1:0] THR_MIN = -16'sd16384;
    localparam logic signed [IN_W-1:0] THR_MAX = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] THR_OFFSET = 17'sd16384;

    // Register reset values
    localparam logic [LIM_W-1:0] RPM_LIMIT_RST   = 15'd32767;
    localparam logic [7:0]       WHEEL_SLOTS_RST = 8'd228;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SPEED_TO_RPM = 3'd0,
        CFG_TURN_TO_RPM  = 3'd1,
        CFG_RPM_LIMIT    = 3'd2,
        CFG_REVERSE      = 3'd3,
        CFG_WHEEL_SLOTS  = 3'd4
    } cfg_addr_t;

    typedef struct packed {
        logic [15:0]      speed_to_rpm;
        logic [15:0]      turn_to_rpm;
        logic [LIM_W-1:0] rpm_limit;
        logic             reverse;
        logic [7:0]       wheel_slots;
    } cfg_t;

    typedef struct packed {
        logic            req_type;
        logic [IN_W-1:0] lin_x;
        logic [IN_W-1:0] lin_y;
        logic [IN_W-1:0] ang_z;
        logic [IN_W-1:0] throttle_axis;
    } cmd_t;

    // Forward, left and turn rpm terms, signed, FRAC_BITS fraction bits
    typedef struct packed {
        logic [TERM_W-1:0] fwd;
        logic [TERM_W-1:0] left;
        logic [TERM_W-1:0] turn;
    } terms_t;

    // Per slot magnitude and sign plus the largest magnitude
    typedef struct packed {
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
        logic [NUM_WHEELS-1:0]            neg;
        logic [MAG_W-1:0]                 maxv;
        logic                             scaled;
    } lanes_t;

    typedef struct packed {
        logic                             scaled;
        logic [NUM_WHEELS-1:0][RPM_W-1:0] rpm;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// File: hdl/mwsm_terms.sv
// Two stage front end: gain products, then rpm terms with 29 fraction bits.
`timescale 1ns / 1ps

module mwsm_terms (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  mwsm_pkg::cmd_t      in_cmd,
    input  mwsm_pkg::cfg_t      cfg,
    output logic                out_valid,
    output mwsm_pkg::terms_t    out_terms
);

    logic                                     s1_valid_reg;
    logic                                     s2_valid_reg;
    logic                                     mode_reg;
    logic [2:0][mwsm_pkg::PROD_W-1:0]         prod_next;
    logic [2:0][mwsm_pkg::PROD_W-1:0]         prod_reg;
    logic [2:0][mwsm_pkg::TERM_W-1:0]         term_next;
    logic [2:0][mwsm_pkg::TERM_W-1:0]         term_reg;

    // Stage 1: throttle clamp and the first multiply per axis
    always_comb begin
        logic signed [mwsm_pkg::IN_W-1:0]   thr_clamp;
        logic signed [mwsm_pkg::GAIN_W-1:0] thr_frac;
        logic signed [mwsm_pkg::GAIN_W-1:0] lin_gain;
        logic signed [mwsm_pkg::GAIN_W-1:0] ang_gain;
        logic signed [mwsm_pkg::GAIN_W-1:0] axis [3];
        priority if ($signed(in_cmd.throttle_axis) < mwsm_pkg::THR_MIN) begin
            thr_clamp = mwsm_pkg::THR_MIN;
        end else if ($signed(in_cmd.throttle_axis) > mwsm_pkg::THR_MAX) begin
            thr_clamp = mwsm_pkg::THR_MAX;
        end else begin
            thr_clamp = $signed(in_cmd.throttle_axis);
        end
        thr_frac = $signed({thr_clamp[mwsm_pkg::IN_W-1], thr_clamp}) + mwsm_pkg::THR_OFFSET;
        lin_gain = in_cmd.req_type ? thr_frac : $signed({1'b0, cfg.speed_to_rpm});
        ang_gain = in_cmd.req_type ? thr_frac : $signed({1'b0, cfg.turn_to_rpm});
        axis[0] = $signed({in_cmd.lin_x[mwsm_pkg::IN_W-1], in_cmd.lin_x});
        axis[1] = $signed({in_cmd.lin_y[mwsm_pkg::IN_W-1], in_cmd.lin_y});
        axis[2] = $signed({in_cmd.ang_z[mwsm_pkg::IN_W-1], in_cmd.ang_z});
        prod_next[0] = lin_gain * axis[0];
        prod_next[1] = lin_gain * axis[1];
        prod_next[2] = ang_gain * axis[2];
    end

    // Stage 2: velocity mode shifts into place, joystick mode multiplies by the limit
    always_comb begin
        logic signed [mwsm_pkg::PROD_W+mwsm_pkg::LIM_W:0] prod_lim;
        for (int i = 0; i < 3; i++) begin
            prod_lim = $signed(prod_reg[i]) * $signed({1'b0, cfg.rpm_limit});
            if (mode_reg) begin
                term_next[i] = prod_lim[mwsm_pkg::TERM_W-1:0];
            end else begin
                term_next[i] = {{(mwsm_pkg::TERM_W-mwsm_pkg::PROD_W-mwsm_pkg::VEL_SHIFT)
                                 {prod_reg[i][mwsm_pkg::PROD_W-1]}},
                                prod_reg[i], {mwsm_pkg::VEL_SHIFT{1'b0}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        mode_reg <= in_cmd.req_type;
        term_reg <= term_next;
    end

    assign out_valid      = s2_valid_reg;
    assign out_terms.fwd  = term_reg[0];
    assign out_terms.left = term_reg[1];
    assign out_terms.turn = term_reg[2];

endmodule

// File: hdl/mwsm_mixer.sv
// Wheel mixing, slot routing, magnitudes and the four way maximum over four stages.
`timescale 1ns / 1ps

module mwsm_mixer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  mwsm_pkg::terms_t    in_terms,
    input  mwsm_pkg::cfg_t      cfg,
    output logic                out_valid,
    output mwsm_pkg::lanes_t    out_lanes
);

    localparam int NW = mwsm_pkg::NUM_WHEELS;

    logic [3:0]                               valid_reg;
    logic [NW-1:0][mwsm_pkg::TERM_W-1:0]      wheel_next;
    logic [NW-1:0][mwsm_pkg::TERM_W-1:0]      wheel_reg;
    logic [NW-1:0][mwsm_pkg::MAG_W-1:0]       mag_next;
    logic [NW-1:0]                            neg_next;
    logic [NW-1:0][mwsm_pkg::MAG_W-1:0]       mag4_reg;
    logic [NW-1:0]                            neg4_reg;
    logic [NW-1:0][mwsm_pkg::MAG_W-1:0]       mag5_reg;
    logic [NW-1:0]                            neg5_reg;
    logic [mwsm_pkg::MAG_W-1:0]               max01_reg;
    logic [mwsm_pkg::MAG_W-1:0]               max23_reg;
    logic [mwsm_pkg::MAG_W-1:0]               max_next;
    logic                                     scaled_next;
    mwsm_pkg::lanes_t                         lanes_reg;

    // Stage 3: fixed mecanum signs, optional reverse
    always_comb begin
        logic signed [mwsm_pkg::TERM_W-1:0] f;
        logic signed [mwsm_pkg::TERM_W-1:0] l;
        logic signed [mwsm_pkg::TERM_W-1:0] o;
        logic signed [mwsm_pkg::TERM_W-1:0] sum [NW];
        f = $signed(in_terms.fwd);
        l = $signed(in_terms.left);
        o = $signed(in_terms.turn);
        sum[0] = f - l - o;
        sum[1] = -f - l - o;
        sum[2] = f + l - o;
        sum[3] = -f + l - o;
        for (int i = 0; i < NW; i++) begin
            wheel_next[i] = cfg.reverse ? -sum[i] : sum[i];
        end
    end

    // Stage 4: route wheels to slots (later wheel wins), split sign and magnitude
    always_comb begin
        logic [mwsm_pkg::TERM_W-1:0] slot_v;
        logic [mwsm_pkg::TERM_W-1:0] abs_v;
        for (int k = 0; k < NW; k++) begin
            slot_v = '0;
            for (int i = 0; i < NW; i++) begin
                if (cfg.wheel_slots[2*i +: 2] == 2'(k)) begin
                    slot_v = wheel_reg[i];
                end
            end
            neg_next[k] = slot_v[mwsm_pkg::TERM_W-1];
            abs_v       = neg_next[k] ? -slot_v : slot_v;
            mag_next[k] = abs_v[mwsm_pkg::MAG_W-1:0];
        end
    end

    // Stage 6: final maximum and the limit check
    always_comb begin
        max_next    = (max01_reg > max23_reg) ? max01_reg : max23_reg;
        scaled_next = max_next >
                      mwsm_pkg::MAG_W'({cfg.rpm_limit, {mwsm_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        wheel_reg <= wheel_next;
        mag4_reg  <= mag_next;
        neg4_reg  <= neg_next;
        // Stage 5: pairwise maxima
        mag5_reg  <= mag4_reg;
        neg5_reg  <= neg4_reg;
        max01_reg <= (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        max23_reg <= (mag4_reg[2] > mag4_reg[3]) ? mag4_reg[2] : mag4_reg[3];
        lanes_reg.mag    <= mag5_reg;
        lanes_reg.neg    <= neg5_reg;
        lanes_reg.maxv   <= max_next;
        lanes_reg.scaled <= scaled_next;
    end

    assign out_valid = valid_reg[3];
    assign out_lanes = lanes_reg;

endmodule

// File: hdl/mwsm_divider.sv
// Pipelined scaling: magnitude times limit, then one quotient bit per stage.
`timescale 1ns / 1ps

module mwsm_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  mwsm_pkg::lanes_t    in_lanes,
    input  mwsm_pkg::cfg_t      cfg,
    output logic                out_valid,
    output mwsm_pkg::result_t   out_result
);

    localparam int NW = mwsm_pkg::NUM_WHEELS;
    localparam int QW = mwsm_pkg::Q_W;
    localparam int MW = mwsm_pkg::MAG_W;

    typedef struct packed {
        logic [NW-1:0][MW-1:0]             rem;
        logic [NW-1:0][QW-1:0]             low;
        logic [NW-1:0][QW-1:0]             quo;
        logic [NW-1:0][mwsm_pkg::LIM_W-1:0] ushift;
        logic [NW-1:0]                     neg;
        logic [MW-1:0]                     divisor;
        logic                              scaled;
    } div_t;

    logic [QW:0] valid_reg;
    div_t        st0_next;
    div_t        st_next [1:QW];
    div_t        st_reg  [0:QW];

    // Stage 0: numerator = magnitude * limit; top bits seed the remainder
    always_comb begin
        logic [mwsm_pkg::NUM_W-1:0] num;
        st0_next.divisor = in_lanes.maxv;
        st0_next.scaled  = in_lanes.scaled;
        st0_next.neg     = in_lanes.neg;
        st0_next.quo     = '0;
        for (int i = 0; i < NW; i++) begin
            num                 = in_lanes.mag[i] * cfg.rpm_limit;
            st0_next.rem[i]     = num[mwsm_pkg::NUM_W-1:QW];
            st0_next.low[i]     = num[QW-1:0];
            st0_next.ushift[i]  = in_lanes.mag[i][mwsm_pkg::FRAC_BITS +: mwsm_pkg::LIM_W];
        end
    end

    // Restoring division, one quotient bit per stage; each stage reads only the register of the stage before it
    always_comb begin
        logic [MW:0] trial;
        logic [MW:0] diff;
        logic        ge;
        for (int g = 1; g <= QW; g++) begin
            st_next[g] = st_reg[g-1];
            for (int i = 0; i < NW; i++) begin
                trial = {st_reg[g-1].rem[i], st_reg[g-1].low[i][QW-1]};
                diff  = trial - {1'b0, st_reg[g-1].divisor};
                ge    = trial >= {1'b0, st_reg[g-1].divisor};
                st_next[g].rem[i] = ge ? diff[MW-1:0] : trial[MW-1:0];
                st_next[g].low[i] = {st_reg[g-1].low[i][QW-2:0], 1'b0};
                st_next[g].quo[i] = {st_reg[g-1].quo[i][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        st_reg[0] <= st0_next;
        for (int g = 1; g <= QW; g++) begin
            st_reg[g] <= st_next[g];
        end
    end

    // Pick scaled quotient or truncated value, restore the sign
    always_comb begin
        logic [mwsm_pkg::LIM_W-1:0] r;
        logic [mwsm_pkg::RPM_W-1:0] ext;
        out_result.scaled = st_reg[QW].scaled;
        for (int i = 0; i < NW; i++) begin
            r   = st_reg[QW].scaled ? st_reg[QW].quo[i] : st_reg[QW].ushift[i];
            ext = mwsm_pkg::RPM_W'(r);
            out_result.rpm[i] = st_reg[QW].neg[i] ? -ext : ext;
        end
    end

    assign out_valid = valid_reg[QW];

endmodule

// File: hdl/mwsm_out_fifo.sv
// Result queue that absorbs every item in flight so the pipeline never stalls.
`timescale 1ns / 1ps

module mwsm_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  mwsm_pkg::result_t     wr_data,
    input  logic                  rd_en,
    output mwsm_pkg::result_t     rd_data,
    output mwsm_pkg::fifo_stat_t  status
);

    mwsm_pkg::result_t                mem_reg [mwsm_pkg::FIFO_DEPTH];
    logic [mwsm_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [mwsm_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [mwsm_pkg::CNT_W-1:0]       count_reg;
    logic [mwsm_pkg::CNT_W-1:0]       count_next;

    // Occupancy
    always_comb begin
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == mwsm_pkg::CNT_W'(mwsm_pkg::FIFO_DEPTH));

endmodule

// File: hdl/mecanum_wheel_speed_mapper_top.sv
// Mecanum wheel speed mapper top level: config registers, pipeline, output queue.
// Path from input accept to m_tvalid: product stages, mixer stages, divider stages, then the queue.
// Throughput: one item per cycle; the free-running pipeline plus a 32-entry result queue
// caps items in flight at 32, so s_tready drops only when that many are undelivered.
// Reset (aresetn low, synchronous): clears valid bits, queue and in-flight count,
// and returns the registers to speed 0, turn 0, limit 32767, no reverse, slots 228.
`timescale 1ns / 1ps

module mecanum_wheel_speed_mapper_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // lin_x, lin_y, ang_z, throttle_axis
    input  logic [0:0]                        s_tuser,   // req_type
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // rpm_slot0, rpm_slot1, rpm_slot2, rpm_slot3
    output logic [0:0]                        m_tuser,   // was_scaled
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [mwsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    mwsm_pkg::cfg_t                   cfg_reg;
    mwsm_pkg::cmd_t                   cmd;
    mwsm_pkg::terms_t                 terms;
    mwsm_pkg::lanes_t                 lanes;
    mwsm_pkg::result_t                div_result;
    mwsm_pkg::result_t                q_result;
    mwsm_pkg::fifo_stat_t             q_stat;
    logic                             terms_valid;
    logic                             lanes_valid;
    logic                             div_valid;
    logic                             in_acc;
    logic                             out_acc;
    logic [mwsm_pkg::CNT_W-1:0]       inflight_reg;
    logic [mwsm_pkg::CNT_W-1:0]       inflight_next;
    logic [mwsm_pkg::NUM_WHEELS-1:0]  slot_in_range;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_to_rpm <= '0;
            cfg_reg.turn_to_rpm  <= '0;
            cfg_reg.rpm_limit    <= mwsm_pkg::RPM_LIMIT_RST;
            cfg_reg.reverse      <= 1'b0;
            cfg_reg.wheel_slots  <= mwsm_pkg::WHEEL_SLOTS_RST;
        end else if (cfg_wr_en) begin
            unique case (mwsm_pkg::cfg_addr_t'(cfg_addr))
                mwsm_pkg::CFG_SPEED_TO_RPM: cfg_reg.speed_to_rpm <= cfg_wdata;
                mwsm_pkg::CFG_TURN_TO_RPM:  cfg_reg.turn_to_rpm  <= cfg_wdata;
                mwsm_pkg::CFG_RPM_LIMIT:    cfg_reg.rpm_limit    <= cfg_wdata[mwsm_pkg::LIM_W-1:0];
                mwsm_pkg::CFG_REVERSE:      cfg_reg.reverse      <= cfg_wdata[0];
                mwsm_pkg::CFG_WHEEL_SLOTS:  cfg_reg.wheel_slots  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input unpacking
    assign cmd.req_type      = s_tuser[0];
    assign cmd.lin_x         = s_tdata[15:0];
    assign cmd.lin_y         = s_tdata[31:16];
    assign cmd.ang_z         = s_tdata[47:32];
    assign cmd.throttle_axis = s_tdata[63:48];

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;

    // Items in flight: accepted but not yet delivered
    always_comb begin
        unique case ({in_acc, out_acc})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    assign s_tready = (inflight_reg != mwsm_pkg::CNT_W'(mwsm_pkg::FIFO_DEPTH));

    mwsm_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_acc),
        .in_cmd    (cmd),
        .cfg       (cfg_reg),
        .out_valid (terms_valid),
        .out_terms (terms)
    );

    mwsm_mixer u_mixer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (terms_valid),
        .in_terms  (terms),
        .cfg       (cfg_reg),
        .out_valid (lanes_valid),
        .out_lanes (lanes)
    );

    mwsm_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (lanes_valid),
        .in_lanes   (lanes),
        .cfg        (cfg_reg),
        .out_valid  (div_valid),
        .out_result (div_result)
    );

    mwsm_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (div_valid),
        .wr_data (div_result),
        .rd_en   (out_acc),
        .rd_data (q_result),
        .status  (q_stat)
    );

    assign m_tvalid   = !q_stat.empty;
    assign m_tdata    = q_result.rpm;
    assign m_tuser[0] = q_result.scaled;

    // Every delivered slot stays within +/- rpm_limit
    always_comb begin
        logic signed [mwsm_pkg::RPM_W:0] lim_s;
        logic signed [mwsm_pkg::RPM_W:0] val_s;
        lim_s = $signed({2'b00, cfg_reg.rpm_limit});
        for (int i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
            val_s = $signed({q_result.rpm[i][mwsm_pkg::RPM_W-1], q_result.rpm[i]});
            slot_in_range[i] = (val_s <= lim_s) && (val_s >= -lim_s);
        end
    end

    // The queue is sized for every item in flight, so it never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid |-> !q_stat.full)
        else $error("result queue written while full");

    // In-flight count never passes the queue depth
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= mwsm_pkg::CNT_W'(mwsm_pkg::FIFO_DEPTH))
        else $error("items in flight exceed queue depth");

    // Output slots respect the configured limit
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (&slot_in_range))
        else $error("output rpm beyond rpm_limit");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result visible right after reset");

endmodule

// File: tb/mecanum_wheel_speed_mapper_top_tb.sv
// Testbench for the mecanum wheel speed mapper: directed and random commands against a wheel-mix model.
`timescale 1ns / 1ps

module mecanum_wheel_speed_mapper_top_tb;
    import mwsm_pkg::*;

    localparam int MAX_IDLE    = 17;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_ITEMS  = 1200;
    localparam int RAND_PHASES = 8;
    localparam int MAX_PRINTS  = 100;
    localparam logic [15:0] CORNER_VALS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // local copy of the configuration registers
    longint unsigned gain_lin;
    longint unsigned gain_turn;
    longint unsigned lim_rpm;
    bit              flip_dir;
    logic [7:0]      slot_map;

    result_t rpm_expected[$];
    int      mismatches  = 0;
    bit      src_idle    = 1'b1;
    bit      sink_idle   = 1'b1;
    int      sink_hold   = 0;
    int      quiet_cycles = 0;

    mecanum_wheel_speed_mapper_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Expected slot rpms for one command, exact 64-bit fixed point
    function automatic result_t wheel_rpms(cmd_t c);
        longint          fwd, left, turn, thr;
        longint          wheel [NUM_WHEELS];
        longint          slot [NUM_WHEELS];
        longint unsigned amp [NUM_WHEELS];
        longint unsigned peak;
        longint unsigned q;
        result_t         r;
        peak = 0;
        for (int i = 0; i < NUM_WHEELS; i++) slot[i] = 0;
        if (c.req_type == 1'b0) begin
            // velocity: Q8.8 input times Q8.8 gain, moved up to 29 fraction bits
            fwd  = longint'($signed(c.lin_x)) * longint'(gain_lin) * 8192;
            left = longint'($signed(c.lin_y)) * longint'(gain_lin) * 8192;
            turn = longint'($signed(c.ang_z)) * longint'(gain_turn) * 8192;
        end else begin
            // joystick: clamped throttle shifted to 0..2 (Q1.14) times axis times limit
            thr = longint'($signed(c.throttle_axis));
            if (thr < longint'(THR_MIN)) thr = longint'(THR_MIN);
            if (thr > longint'(THR_MAX)) thr = longint'(THR_MAX);
            thr  = thr + 16384;
            fwd  = thr * longint'($signed(c.lin_x)) * longint'(lim_rpm);
            left = thr * longint'($signed(c.lin_y)) * longint'(lim_rpm);
            turn = thr * longint'($signed(c.ang_z)) * longint'(lim_rpm);
        end
        wheel[0] = fwd - left - turn;
        wheel[1] = -fwd - left - turn;
        wheel[2] = fwd + left - turn;
        wheel[3] = -fwd + left - turn;
        // later wheels win a shared slot
        for (int i = 0; i < NUM_WHEELS; i++)
            slot[slot_map[2*i +: 2]] = flip_dir ? -wheel[i] : wheel[i];
        for (int i = 0; i < NUM_WHEELS; i++) begin
            amp[i] = (slot[i] < 0) ? -slot[i] : slot[i];
            if (amp[i] > peak) peak = amp[i];
        end
        r.scaled = peak > (lim_rpm << FRAC_BITS);
        for (int i = 0; i < NUM_WHEELS; i++) begin
            q = r.scaled ? (amp[i] * lim_rpm) / peak : (amp[i] >> FRAC_BITS);
            r.rpm[i] = (slot[i] < 0) ? RPM_W'(-longint'(q)) : RPM_W'(q);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got, want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch on %s: got %0d, expected %0d",
                     $time, what, $signed(got), $signed(want));
    endtask

    // Send one command item, with a random gap in front when the source idles
    task automatic send_cmd(input logic req, input logic [15:0] x, y, z, thr);
        int   gap;
        cmd_t c;
        gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
        c.req_type      = req;
        c.lin_x         = x;
        c.lin_y         = y;
        c.ang_z         = z;
        c.throttle_axis = thr;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {thr, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rpm_expected.push_back(wheel_rpms(c));
    endtask

    // Every command gives a result, so an empty queue means the pipeline is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (rpm_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_addr_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Drain, then write all five registers back to back
    task automatic load_setup(input logic [15:0] lin_k, turn_k, input logic [14:0] lim_k,
                              input logic rev, input logic [7:0] slots);
        wait_idle();
        cfg_write(CFG_SPEED_TO_RPM, lin_k);
        cfg_write(CFG_TURN_TO_RPM, turn_k);
        cfg_write(CFG_RPM_LIMIT, {1'b0, lim_k});
        cfg_write(CFG_REVERSE, {15'd0, rev});
        cfg_write(CFG_WHEEL_SLOTS, {8'd0, slots});
        cfg_wr_en <= 1'b0;
        gain_lin  = lin_k;
        gain_turn = turn_k;
        lim_rpm   = lim_k;
        flip_dir  = rev;
        slot_map  = slots;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 32768)) - 16384);
            2:       return 16'(int'($urandom_range(0, 1200)) - 600);
            default: return CORNER_VALS[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [15:0] rand_throttle();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [14:0] rand_limit();
        case ($urandom_range(0, 3))
            0:       return 15'd1;
            1:       return 15'd32767;
            2:       return 15'($urandom_range(1, 32767));
            default: return 15'($urandom_range(1, 300));
        endcase
    endfunction

    // Register defaults: speed and turn gains are zero, joystick uses the full limit
    task automatic test_reset_values();
        send_cmd(1'b1, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
        send_cmd(1'b0, 16'h7FFF, 16'h8000, 16'sd100, 16'sd0);
        send_cmd(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'sd16384);
    endtask

    // Largest gains with extreme velocity inputs
    task automatic test_gain_extremes();
        load_setup(16'hFFFF, 16'hFFFF, 15'd32767, 1'b0, WHEEL_SLOTS_RST);
        send_cmd(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_cmd(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_cmd(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
        send_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    endtask

    // Throttle outside its range clamps; axes beyond one pass through
    task automatic test_throttle_clamp();
        load_setup(16'd256, 16'd512, 15'd3000, 1'b0, WHEEL_SLOTS_RST);
        send_cmd(1'b1, 16'sd8192, 16'sd4096, -16'sd4096, 16'h8000);
        send_cmd(1'b1, 16'sd8192, 16'sd4096, -16'sd4096, 16'h7FFF);
        send_cmd(1'b1, 16'sd2000, -16'sd300, 16'sd700, -16'sd16385);
        send_cmd(1'b1, 16'sd2000, -16'sd300, 16'sd700, 16'sd16385);
        send_cmd(1'b1, 16'h7FFF, 16'h8000, 16'sd50, 16'sd0);
    endtask

    // Reverse, shared slots, unassigned slots and a permuted map
    task automatic test_slot_map();
        load_setup(16'd256, 16'd512, 15'd1000, 1'b1, 8'h00);
        send_cmd(1'b0, 16'sd2560, -16'sd1280, 16'sd300, 16'h0000);
        send_cmd(1'b1, -16'sd4000, 16'sd9000, 16'sd1000, 16'sd0);
        load_setup(16'd256, 16'd512, 15'd1000, 1'b0, 8'h5A);
        send_cmd(1'b0, 16'sd2560, -16'sd1280, 16'sd300, 16'h0000);
        load_setup(16'd700, 16'd90, 15'd500, 1'b1, 8'h1B);
        send_cmd(1'b0, -16'sd900, 16'sd3000, -16'sd20000, 16'h0000);
        send_cmd(1'b0, 16'sd100, 16'sd40, 16'sd10, 16'h0000);
    endtask

    // A zero limit forces every nonzero result to zero with scaling flagged
    task automatic test_zero_limit();
        load_setup(16'hFFFF, 16'hFFFF, 15'd0, 1'b0, WHEEL_SLOTS_RST);
        send_cmd(1'b0, 16'sd1000, 16'sd0, 16'sd0, 16'h0000);
        send_cmd(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
        send_cmd(1'b1, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    endtask

    // Random commands over a series of register settings and idle patterns
    task automatic test_random_mix();
        logic [15:0] lin_k, turn_k;
        logic [14:0] lim_k;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    lin_k = 16'hFFFF; turn_k = 16'hFFFF; lim_k = 15'd32767;
                end
                1: begin
                    lin_k = 16'h0001; turn_k = 16'h0000; lim_k = 15'd1;
                end
                default: begin
                    lin_k = rand_gain(); turn_k = rand_gain(); lim_k = rand_limit();
                end
            endcase
            load_setup(lin_k, turn_k, lim_k, 1'($urandom_range(0, 1)),
                       (p % 2 == 0) ? 8'($urandom) : 8'h1B);
            src_idle  = (p % 3 != 2);
            sink_idle = (p % 4 != 1);
            for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++)
                send_cmd(1'($urandom_range(0, 1)), rand_axis(), rand_axis(), rand_axis(),
                         rand_throttle());
        end
    endtask

    // Result checker
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rpm_expected.size() == 0) begin
                report_mismatch("result with no command waiting", m_tdata[15:0], 16'd0);
            end else begin
                want = rpm_expected.pop_front();
                for (int i = 0; i < NUM_WHEELS; i++)
                    if (m_tdata[RPM_W*i +: RPM_W] !== want.rpm[i])
                        report_mismatch($sformatf("rpm_slot%0d", i),
                                        m_tdata[RPM_W*i +: RPM_W], want.rpm[i]);
                if (m_tuser[0] !== want.scaled)
                    report_mismatch("was_scaled", {15'd0, m_tuser[0]}, {15'd0, want.scaled});
            end
        end
    end

    // Result sink: random stall after each item taken while the sink idles
    always @(posedge aclk) begin : sink_ready
        int hold;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            hold = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            sink_hold <= hold;
            m_tready  <= (hold == 0);
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        gain_lin  = 0;
        gain_turn = 0;
        lim_rpm   = RPM_LIMIT_RST;
        flip_dir  = 1'b0;
        slot_map  = WHEEL_SLOTS_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_gain_extremes();
        test_throttle_clamp();
        test_slot_map();
        test_zero_limit();
        test_random_mix();
        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
